@@ rtl/kls_pkg.sv @@
// keymap layer stack: shared types, widths and codes
// no dependencies; used by the interfaces and every module except kls_ram
package kls_pkg;

  localparam int REQ_W      = 3;
  localparam int ADDR_W     = 6;
  localparam int LIDX_W     = 5;
  localparam int KEY_W      = 16;
  localparam int CNT_W      = 6;
  localparam int MASK_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int QDEPTH     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_LAYER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_KEY     = 2'd2;

  localparam logic [CNT_W-1:0]  RST_LAYER_COUNT   = 6'd32;
  localparam logic [LIDX_W-1:0] RST_DEFAULT_LAYER = 5'd0;
  localparam logic [KEY_W-1:0]  RST_CLEAR_KEY     = 16'hFFFF;
  localparam logic [MASK_W-1:0] RST_MASK          = 32'd1;

  typedef enum logic [REQ_W-1:0] {
    OP_LOOKUP        = 3'd0,
    OP_ACTIVATE      = 3'd1,
    OP_DEACTIVATE    = 3'd2,
    OP_TOGGLE        = 3'd3,
    OP_SHIFT_PRESS   = 3'd4,
    OP_SHIFT_RELEASE = 3'd5,
    OP_LOAD          = 3'd6,
    OP_NONE          = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_RESCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] key_pos;
    logic [LIDX_W-1:0] layer_sel;
    logic [KEY_W-1:0]  key_data;
    logic              addr_ok;
    logic              store_ok;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0]  layer_count;
    logic [LIDX_W-1:0] default_layer;
    logic [KEY_W-1:0]  clear_key;
  } cfg_t;

endpackage

@@ rtl/kls_req_if.sv @@
// request channel: valid/ready plus one request item
// depends on kls_pkg
interface kls_req_if;
  import kls_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [ADDR_W-1:0] key_pos;
  logic [LIDX_W-1:0] layer_sel;
  logic [KEY_W-1:0]  key_data;

  modport source (output valid, req_type, key_pos, layer_sel, key_data, input ready);
  modport sink (input valid, req_type, key_pos, layer_sel, key_data, output ready);
endinterface

@@ rtl/kls_rsp_if.sv @@
// response channel: valid/ready plus one result item
// depends on kls_pkg
interface kls_rsp_if;
  import kls_pkg::*;

  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  key_value;
  logic [LIDX_W-1:0] found_layer;
  logic [LIDX_W-1:0] top_layer;
  logic [MASK_W-1:0] active_mask;

  modport source (output valid, key_value, found_layer, top_layer, active_mask, input ready);
  modport sink (input valid, key_value, found_layer, top_layer, active_mask, output ready);
endinterface

@@ rtl/kls_cfg_if.sv @@
// configuration write channel: valid/ready, register index and data
// depends on kls_pkg
interface kls_cfg_if;
  import kls_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/keymap_layer_stack.sv @@
// keymap layer stack top level: config registers, front queue, back end, keymap store
// depends on kls_pkg, the kls_*_if interfaces, kls_front, kls_back and kls_ram
// lookup: from dequeue through ST_LOOKUP, stepping down at most 31 layers, to ST_DONE, with
//   at most one keymap store read per cycle through the single store port
// rescan: one layer tested per cycle; other requests go from dequeue straight to ST_DONE
// the front queue holds two requests while the back end is busy
// reset: only layer 0 active, top layer 0, config to defaults, store undefined until loaded
module keymap_layer_stack #(
  parameter int LAYERS = 32,
  parameter int KEYS   = 64
) (
  input  logic       clk,
  input  logic       rst,
  kls_req_if.sink    req,
  kls_rsp_if.source  rsp,
  kls_cfg_if.sink    cfg
);
  import kls_pkg::*;

  localparam int DEPTH = LAYERS * KEYS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [MASK_W-1:0] USED_MASK =
    (LAYERS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((64'd1 << LAYERS) - 64'd1);

  cfg_t             cfg_regs;
  logic             cmd_valid;
  cmd_t             cmd;
  logic             cmd_pop;
  logic             ram_en;
  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [KEY_W-1:0] ram_wdata;
  logic [KEY_W-1:0] ram_rdata;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.layer_count   <= RST_LAYER_COUNT;
      cfg_regs.default_layer <= RST_DEFAULT_LAYER;
      cfg_regs.clear_key     <= RST_CLEAR_KEY;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_LAYER_COUNT:   cfg_regs.layer_count   <= cfg.data[CNT_W-1:0];
        CFG_DEFAULT_LAYER: cfg_regs.default_layer <= cfg.data[LIDX_W-1:0];
        CFG_CLEAR_KEY:     cfg_regs.clear_key     <= cfg.data[KEY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  kls_front #(
    .LAYERS (LAYERS),
    .KEYS   (KEYS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  kls_back #(
    .LAYERS (LAYERS),
    .KEYS   (KEYS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .cfg       (cfg_regs),
    .rsp       (rsp),
    .ram_en    (ram_en),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

  kls_ram #(
    .WIDTH (KEY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  a_found_below_top: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.found_layer <= rsp.top_layer)
    else $error("lookup stopped above the top layer");

  a_mask_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.active_mask & ~USED_MASK) == '0)
    else $error("layer beyond the store marked active");

  a_store_write_on_pop: assert property (@(posedge clk) disable iff (rst)
    (ram_en && ram_we) |-> (cmd_pop && cmd.op == OP_LOAD))
    else $error("store written outside a load transaction");

endmodule

@@ rtl/kls_ram.sv @@
// generic single-port ram with registered read
// no dependencies
module kls_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                        wdata,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

@@ rtl/kls_front.sv @@
// front end: accepts requests, classifies them and queues commands
// depends on kls_pkg and kls_req_if
module kls_front #(
  parameter int LAYERS = 32,
  parameter int KEYS   = 64
) (
  input  logic           clk,
  input  logic           rst,
  kls_req_if.sink        req,
  output logic           cmd_valid,
  output kls_pkg::cmd_t  cmd,
  input  logic           cmd_pop
);
  import kls_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  cmd_t          q [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  cmd_t          cls;
  logic          push;

  always_comb begin
    cls.op        = op_t'(req.req_type);
    cls.key_pos   = req.key_pos;
    cls.layer_sel = req.layer_sel;
    cls.key_data  = req.key_data;
    cls.addr_ok   = 32'(req.key_pos) < 32'(KEYS);
    cls.store_ok  = 32'(req.layer_sel) < 32'(LAYERS);
  end

  assign req.ready = count != CW'(QDEPTH);
  assign push      = req.valid && req.ready;
  assign cmd_valid = count != '0;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !cmd_pop) begin
        count <= count + 1'b1;
      end else if (!push && cmd_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/kls_back.sv @@
// back end: executes commands on the layer mask, top layer and keymap store
// depends on kls_pkg and kls_rsp_if; drives the port of kls_ram
module kls_back #(
  parameter int LAYERS = 32,
  parameter int KEYS   = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  input  kls_pkg::cmd_t         cmd,
  output logic                  cmd_pop,
  input  kls_pkg::cfg_t         cfg,
  kls_rsp_if.source             rsp,
  output logic                  ram_en,
  output logic                  ram_we,
  output logic [((LAYERS * KEYS > 1) ? $clog2(LAYERS * KEYS) : 1)-1:0] ram_addr,
  output logic [kls_pkg::KEY_W-1:0] ram_wdata,
  input  logic [kls_pkg::KEY_W-1:0] ram_rdata
);
  import kls_pkg::*;

  localparam int DEPTH = LAYERS * KEYS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_t            state, state_next;
  cmd_t              cur, cur_next;
  logic [MASK_W-1:0] mask, mask_next;
  logic [LIDX_W-1:0] top, top_next;
  logic [LIDX_W-1:0] lk_layer, lk_layer_next;
  logic [KEY_W-1:0]  key_reg, key_reg_next;
  logic              pend, pend_next;
  logic              rd_ok, rd_ok_next;
  logic [CNT_W-1:0]  ptr, ptr_next;
  logic [KEY_W-1:0]  res_key, res_key_next;
  logic [LIDX_W-1:0] res_found, res_found_next;

  logic [CNT_W-1:0]  eff;
  logic [KEY_W-1:0]  key_eff;
  logic [LIDX_W-1:0] nl;
  logic [LIDX_W-1:0] scan_idx;
  logic [LIDX_W-1:0] ram_layer;
  logic [ADDR_W-1:0] ram_key;
  logic [31:0]       lin_addr;
  logic              lidx_in;
  logic              out_load;

  assign eff      = (32'(cfg.layer_count) < 32'(LAYERS)) ? cfg.layer_count : CNT_W'(LAYERS);
  assign key_eff  = pend ? (rd_ok ? ram_rdata : '0) : key_reg;
  assign nl       = lk_layer - 1'b1;
  assign scan_idx = LIDX_W'(ptr - 1'b1);
  assign lidx_in  = {1'b0, cmd.layer_sel} < eff;
  assign lin_addr = 32'(ram_layer) * 32'(KEYS) + 32'(ram_key);
  assign ram_addr = lin_addr[AW-1:0];
  assign ram_wdata = cmd.key_data;
  assign out_load = (state == ST_DONE) && (!rsp.valid || rsp.ready);

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    mask_next      = mask;
    top_next       = top;
    lk_layer_next  = lk_layer;
    key_reg_next   = key_reg;
    pend_next      = pend;
    rd_ok_next     = rd_ok;
    ptr_next       = ptr;
    res_key_next   = res_key;
    res_found_next = res_found;
    cmd_pop        = 1'b0;
    ram_en         = 1'b0;
    ram_we         = 1'b0;
    ram_layer      = cmd.layer_sel;
    ram_key        = cmd.key_pos;

    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop        = 1'b1;
          cur_next       = cmd;
          res_key_next   = '0;
          res_found_next = '0;
          state_next     = ST_DONE;
          case (cmd.op)
            OP_LOOKUP: begin
              lk_layer_next = top;
              pend_next     = 1'b1;
              rd_ok_next    = (32'(top) < 32'(LAYERS)) && cmd.addr_ok;
              ram_layer     = top;
              ram_en        = rd_ok_next;
              state_next    = ST_LOOKUP;
            end
            OP_ACTIVATE: begin
              if (lidx_in && !mask[cmd.layer_sel]) begin
                mask_next[cmd.layer_sel] = 1'b1;
                if (cmd.layer_sel > top) top_next = cmd.layer_sel;
              end
            end
            OP_DEACTIVATE: begin
              if (lidx_in && mask[cmd.layer_sel]) begin
                mask_next[cmd.layer_sel] = 1'b0;
                if (cmd.layer_sel == top) begin
                  ptr_next   = eff;
                  state_next = ST_RESCAN;
                end
              end
            end
            OP_TOGGLE: begin
              if (lidx_in) begin
                mask_next[cmd.layer_sel] = !mask[cmd.layer_sel];
                if (mask[cmd.layer_sel]) begin
                  if (cmd.layer_sel == top) begin
                    ptr_next   = eff;
                    state_next = ST_RESCAN;
                  end
                end else if (cmd.layer_sel > top) begin
                  top_next = cmd.layer_sel;
                end
              end
            end
            OP_SHIFT_PRESS: begin
              if (lidx_in) top_next = cmd.layer_sel;
            end
            OP_SHIFT_RELEASE: begin
              ptr_next   = eff;
              state_next = ST_RESCAN;
            end
            OP_LOAD: begin
              ram_en = cmd.store_ok && cmd.addr_ok;
              ram_we = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOOKUP: begin
        ram_key = cur.key_pos;
        ram_layer = nl;
        if (lk_layer == '0 || key_eff != cfg.clear_key) begin
          res_key_next   = key_eff;
          res_found_next = lk_layer;
          state_next     = ST_DONE;
        end else begin
          lk_layer_next = nl;
          key_reg_next  = key_eff;
          pend_next     = mask[nl];
          rd_ok_next    = (32'(nl) < 32'(LAYERS)) && cur.addr_ok;
          ram_en        = mask[nl] && rd_ok_next;
        end
      end
      ST_RESCAN: begin
        if ({1'b0, ptr} > ({2'b0, cfg.default_layer} + 7'd1)) begin
          if (mask[scan_idx]) begin
            top_next   = scan_idx;
            state_next = ST_DONE;
          end else begin
            ptr_next = ptr - 1'b1;
          end
        end else begin
          top_next   = cfg.default_layer;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mask  <= RST_MASK;
      top   <= '0;
    end else begin
      state <= state_next;
      mask  <= mask_next;
      top   <= top_next;
    end
  end

  always_ff @(posedge clk) begin
    cur       <= cur_next;
    lk_layer  <= lk_layer_next;
    key_reg   <= key_reg_next;
    pend      <= pend_next;
    rd_ok     <= rd_ok_next;
    ptr       <= ptr_next;
    res_key   <= res_key_next;
    res_found <= res_found_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.key_value   <= res_key;
      rsp.found_layer <= res_found;
      rsp.top_layer   <= top;
      rsp.active_mask <= mask;
    end
  end

endmodule

@@ bench/tb_keymap_layer_stack.sv @@
// self-checking bench for keymap_layer_stack: directed and random request traffic
// with a cycle-free prediction of the layer stack and keymap store
// depends on kls_pkg, keymap_layer_stack and the kls_req_if, kls_rsp_if and kls_cfg_if interfaces
module tb_keymap_layer_stack;
  timeunit 1ns;
  timeprecision 1ps;
  import kls_pkg::*;

  localparam int NLAYERS = 32;
  localparam int NKEYS   = 64;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] key_pos;
    logic [LIDX_W-1:0] layer_sel;
    logic [KEY_W-1:0]  key_data;
  } request_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key_value;
    logic [LIDX_W-1:0] found_layer;
    logic [LIDX_W-1:0] top_layer;
    logic [MASK_W-1:0] active_mask;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  kls_req_if req_bus ();
  kls_rsp_if rsp_bus ();
  kls_cfg_if cfg_bus ();

  keymap_layer_stack #(.LAYERS(NLAYERS), .KEYS(NKEYS)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus),
    .cfg (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted keymap and layer state
  logic [KEY_W-1:0]  keymap_m [NLAYERS][NKEYS];
  bit                loaded_m [NLAYERS][NKEYS];
  logic [MASK_W-1:0] mask_m = 32'd1;
  int                top_m = 0;
  int                count_m = 32;
  int                dflt_m = 0;
  logic [KEY_W-1:0]  clear_m = 16'hFFFF;

  request_t request_queue[$];
  reply_t   predicted_replies[$];
  int       hot_keys[6] = '{0, 63, 21, 42, 7, 56};
  int       idle_pct = 30;
  bit       backlog_arm = 1'b0;
  int       fault_count = 0;
  logic     req_fire = 1'b0;
  logic     cfg_fire = 1'b0;

  function automatic int live_layers();
    return (count_m < NLAYERS) ? count_m : NLAYERS;
  endfunction

  function automatic void rescan_top();
    int i;
    top_m = dflt_m;
    for (i = live_layers() - 1; i > dflt_m; i--) begin
      if (mask_m[i]) begin
        top_m = i;
        break;
      end
    end
  endfunction

  function automatic void raise_layer(int l);
    if (l >= live_layers() || mask_m[l]) return;
    mask_m[l] = 1'b1;
    if (l > top_m) top_m = l;
  endfunction

  function automatic void drop_layer(int l);
    if (l >= live_layers() || !mask_m[l]) return;
    mask_m[l] = 1'b0;
    if (l == top_m) rescan_top();
  endfunction

  function automatic reply_t step_layer_stack(request_t r);
    reply_t           a;
    int               lyr;
    int               li;
    int               ka;
    logic [KEY_W-1:0] k;
    a = '0;
    li = int'(r.layer_sel);
    ka = int'(r.key_pos);
    case (r.op)
      OP_LOOKUP: begin
        lyr = top_m;
        k = keymap_m[lyr][ka];
        while (lyr > 0 && k == clear_m) begin
          lyr--;
          if (mask_m[lyr]) k = keymap_m[lyr][ka];
        end
        a.key_value = k;
        a.found_layer = LIDX_W'(lyr);
      end
      OP_ACTIVATE: raise_layer(li);
      OP_DEACTIVATE: drop_layer(li);
      OP_TOGGLE: begin
        if (mask_m[li]) drop_layer(li);
        else raise_layer(li);
      end
      OP_SHIFT_PRESS: begin
        if (li < live_layers()) top_m = li;
      end
      OP_SHIFT_RELEASE: rescan_top();
      OP_LOAD: begin
        keymap_m[li][ka] = r.key_data;
        loaded_m[li][ka] = 1'b1;
      end
      default: ;
    endcase
    a.top_layer = LIDX_W'(top_m);
    a.active_mask = mask_m;
    return a;
  endfunction

  function automatic logic [KEY_W-1:0] pick_code();
    int p;
    p = $urandom_range(99);
    if (p < 45) return clear_m;
    if (p < 50) return 16'h0000;
    if (p < 55) return 16'hFFFF;
    return KEY_W'($urandom);
  endfunction

  function automatic int pick_layer();
    int n;
    n = live_layers();
    if (n > 0 && $urandom_range(99) < 80) return $urandom_range(n - 1);
    return $urandom_range(31);
  endfunction

  function automatic int pick_key();
    if ($urandom_range(99) < 80) return hot_keys[$urandom_range(5)];
    return $urandom_range(63);
  endfunction

  function automatic op_t pick_op();
    int p;
    p = $urandom_range(99);
    if (p < 35) return OP_LOOKUP;
    if (p < 55) return OP_LOAD;
    if (p < 66) return OP_ACTIVATE;
    if (p < 77) return OP_DEACTIVATE;
    if (p < 88) return OP_TOGGLE;
    if (p < 93) return OP_SHIFT_PRESS;
    if (p < 98) return OP_SHIFT_RELEASE;
    return OP_NONE;
  endfunction

  // a lookup first gets loads for every entry its walk will read that is not yet loaded
  function automatic void issue(op_t op, int ka, int li, logic [KEY_W-1:0] kd);
    request_t         r;
    int               lyr;
    logic [KEY_W-1:0] k;
    if (op == OP_LOOKUP) begin
      lyr = top_m;
      if (!loaded_m[lyr][ka]) issue(OP_LOAD, ka, lyr, pick_code());
      k = keymap_m[lyr][ka];
      while (lyr > 0 && k == clear_m) begin
        lyr--;
        if (mask_m[lyr]) begin
          if (!loaded_m[lyr][ka]) issue(OP_LOAD, ka, lyr, pick_code());
          k = keymap_m[lyr][ka];
        end
      end
    end
    r.op = op;
    r.key_pos = ADDR_W'(ka);
    r.layer_sel = LIDX_W'(li);
    r.key_data = kd;
    predicted_replies.push_back(step_layer_stack(r));
    request_queue.push_back(r);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fault_count++;
    end
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= CFG_DATA_W'(val);
    do @(negedge clk); while (!cfg_fire);
    cfg_bus.valid <= 1'b0;
    case (idx)
      CFG_LAYER_COUNT:   count_m = val & 63;
      CFG_DEFAULT_LAYER: dflt_m = val & 31;
      CFG_CLEAR_KEY:     clear_m = KEY_W'(val);
      default: ;
    endcase
  endtask

  task automatic drain();
    while (predicted_replies.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int cnt, int dflt, int clr, int idle, int n);
    int i;
    int li;
    op_t op;
    write_reg(CFG_LAYER_COUNT, cnt);
    write_reg(CFG_DEFAULT_LAYER, dflt);
    write_reg(CFG_CLEAR_KEY, clr);
    idle_pct = idle;
    for (i = 0; i < n; i++) begin
      op = pick_op();
      li = pick_layer();
      if ((op == OP_DEACTIVATE || op == OP_TOGGLE) && $urandom_range(99) < 40) li = top_m;
      issue(op, pick_key(), li, pick_code());
    end
    drain();
  endtask

  always @(posedge clk) begin
    req_fire <= req_bus.valid && req_bus.ready;
    cfg_fire <= cfg_bus.valid && cfg_bus.ready;
  end

  always @(negedge clk) begin : drive_req
    request_t nxt;
    if (rst) begin
      req_bus.valid <= 1'b0;
    end else if (!req_bus.valid || req_fire) begin
      if (request_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = request_queue.pop_front();
        req_bus.valid     <= 1'b1;
        req_bus.req_type  <= nxt.op;
        req_bus.key_pos   <= nxt.key_pos;
        req_bus.layer_sel <= nxt.layer_sel;
        req_bus.key_data  <= nxt.key_data;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // long hold-off once, while the sender still has a backlog
  always @(negedge clk) begin : drive_ready
    int stall_left;
    bit backlog_done;
    if (rst) begin
      rsp_bus.ready <= 1'b0;
      stall_left = 0;
      backlog_done = 1'b0;
    end else if (stall_left > 0) begin
      rsp_bus.ready <= 1'b0;
      stall_left--;
    end else if (backlog_arm && !backlog_done && request_queue.size() > 20 &&
                 request_queue.size() < 150) begin
      rsp_bus.ready <= 1'b0;
      stall_left = 300;
      backlog_done = 1'b1;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin : watch_rsp
    reply_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (predicted_replies.size() == 0) begin
        $display("%0t: transaction with nothing expected, actual key %0h layer %0d top %0d mask %0h",
                 $time, rsp_bus.key_value, rsp_bus.found_layer, rsp_bus.top_layer,
                 rsp_bus.active_mask);
        fault_count++;
      end else begin
        want = predicted_replies.pop_front();
        check_field("key_value", 32'(want.key_value), 32'(rsp_bus.key_value));
        check_field("found_layer", 32'(want.found_layer), 32'(rsp_bus.found_layer));
        check_field("top_layer", 32'(want.top_layer), 32'(rsp_bus.top_layer));
        check_field("active_mask", want.active_mask, rsp_bus.active_mask);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("keymap_layer_stack regression: fail");
    $finish;
  end

  initial begin
    req_bus.valid = 1'b0;
    req_bus.req_type = OP_NONE;
    req_bus.key_pos = '0;
    req_bus.layer_sel = '0;
    req_bus.key_data = '0;
    rsp_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_LAYER_COUNT;
    cfg_bus.data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed traffic at reset settings
    issue(OP_LOAD, 0, 0, 16'h0000);
    issue(OP_LOOKUP, 0, 31, 16'hFFFF);
    issue(OP_LOAD, 63, 31, 16'hFFFF);
    issue(OP_LOAD, 63, 0, 16'hABCD);
    issue(OP_ACTIVATE, 0, 31, 16'h0000);
    issue(OP_LOOKUP, 63, 0, 16'h0000);
    issue(OP_SHIFT_PRESS, 0, 5, 16'h0000);
    issue(OP_LOOKUP, 63, 0, 16'h5555);
    issue(OP_ACTIVATE, 0, 3, 16'h0000);
    issue(OP_TOGGLE, 0, 3, 16'h0000);
    issue(OP_TOGGLE, 0, 3, 16'h0000);
    issue(OP_DEACTIVATE, 0, 31, 16'h0000);
    issue(OP_ACTIVATE, 0, 31, 16'h0000);
    issue(OP_DEACTIVATE, 0, 31, 16'h0000);
    issue(OP_SHIFT_RELEASE, 0, 0, 16'h0000);
    issue(OP_DEACTIVATE, 0, 0, 16'h0000);
    issue(OP_LOAD, 0, 3, 16'hFFFF);
    issue(OP_SHIFT_PRESS, 0, 3, 16'h0000);
    issue(OP_LOOKUP, 0, 0, 16'h0000);
    issue(OP_NONE, 63, 31, 16'hFFFF);
    issue(OP_ACTIVATE, 0, 0, 16'h0000);
    issue(OP_LOOKUP, 63, 31, 16'hAAAA);
    drain();

    backlog_arm = 1'b1;
    run_phase(32, 0, $urandom_range(65535), 30, 270);
    run_phase(8, 2, 16'h0000, 0, 270);
    run_phase(0, 5, 16'hFFFF, 30, 150);
    run_phase(63, 31, 16'hFFFF, 30, 200);
    run_phase(1, 20, 16'h8001, 30, 150);
    run_phase($urandom_range(1, 40), $urandom_range(31), $urandom_range(65535), 30, 290);

    repeat (60) @(posedge clk);
    if (fault_count == 0 && predicted_replies.size() == 0) begin
      $display("keymap_layer_stack regression: pass");
    end else begin
      $display("keymap_layer_stack regression: fail");
    end
    $finish;
  end

endmodule

@@ keymap_layer_stack.f @@
rtl/kls_pkg.sv
rtl/kls_req_if.sv
rtl/kls_rsp_if.sv
rtl/kls_cfg_if.sv
rtl/kls_ram.sv
rtl/kls_front.sv
rtl/kls_back.sv
rtl/keymap_layer_stack.sv
bench/tb_keymap_layer_stack.sv
